### hw/rtl/utf8seg_pkg.sv
// ----------------------------------------------------------------------------
// utf8seg_pkg
// Types, constants and helpers shared by the UTF-8 code point segmenter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package utf8seg_pkg;

  // Longest string the offsets are meant to cover; offsets saturate below it.
  localparam int MAX_BYTES    = 65536;
  localparam int POS_CAP_INT  = (MAX_BYTES - 1 < 65535) ? (MAX_BYTES - 1) : 65535;
  localparam logic [15:0] POS_CAP = 16'(POS_CAP_INT);

  localparam int MAX_UNITS = 4;  // most units one byte can release

  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_CODE = 8'h80;
  localparam logic [7:0] ASCII_TOP = 8'h80;
  localparam logic [2:0] LEAD2_CODE = 3'h6;
  localparam logic [3:0] LEAD3_CODE = 4'hE;
  localparam logic [4:0] LEAD4_CODE = 5'h1E;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
    logic       no_byte;
  } byte_item_t;

  typedef struct packed {
    logic [15:0] unit_offset;
    logic [2:0]  unit_length;
    logic [15:0] unit_index;
    logic        last_unit;
  } unit_item_t;

  // All units released by one byte transaction.
  typedef struct packed {
    logic [2:0]                  count;
    unit_item_t [MAX_UNITS-1:0] units;
  } unit_bundle_t;

  // Length a byte asks for when it opens a unit; 1 for anything that is not a lead.
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd1;
    if (b < ASCII_TOP)              len = 3'd1;
    else if (b[7:5] == LEAD2_CODE)  len = 3'd2;
    else if (b[7:4] == LEAD3_CODE)  len = 3'd3;
    else if (b[7:3] == LEAD4_CODE)  len = 3'd4;
    return len;
  endfunction

  // Saturating add of a small step to an offset or index.
  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [2:0] k);
    logic [16:0] s;
    s = {1'b0, a} + {14'b0, k};
    return (s > {1'b0, POS_CAP}) ? POS_CAP : s[15:0];
  endfunction

endpackage

### hw/rtl/utf8_code_point_segmenter.sv
// ----------------------------------------------------------------------------
// utf8_code_point_segmenter
// Splits a byte stream into UTF-8 code point units: offset, length, index
// and a last mark for each unit.
// ----------------------------------------------------------------------------
// One byte is taken per clock while byte_stall is low. Each byte transaction is
// decoded combinationally into the 0 to 4 units it releases, which go into a
// two-deep queue of unit bundles; the output side drains that queue one unit per
// cycle while unit_stall is low. A byte that releases at most one unit therefore
// flows at one per cycle, while a broken multi-byte unit (up to four results from
// one byte) can fill the queue and hold the input off until a bundle is drained.
// byte_stall is driven from registered queue occupancy only.
`timescale 1ns / 1ps

module utf8_code_point_segmenter (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    byte_valid,
  output logic                    byte_stall,
  input  utf8seg_pkg::byte_item_t byte_data,
  output logic                    unit_valid,
  input  logic                    unit_stall,
  output utf8seg_pkg::unit_item_t unit_data
);

  // decoder state
  logic [1:0]  held_bytes, held_bytes_next;
  logic [2:0]  expected_length, expected_length_next;
  logic [15:0] lead_offset, lead_offset_next;
  logic [15:0] byte_position, byte_position_next;
  logic [15:0] unit_counter, unit_counter_next;

  // bundle queue
  utf8seg_pkg::unit_bundle_t q [2];
  utf8seg_pkg::unit_bundle_t bundle;
  logic [1:0] q_count;
  logic       q_rd, q_wr;
  logic [1:0] rp;

  logic [15:0] e_off [utf8seg_pkg::MAX_UNITS];
  logic [2:0]  e_len [utf8seg_pkg::MAX_UNITS];
  logic [2:0]  n_units;
  logic        accept, push, pop, unit_take;
  logic        rescan;
  logic [2:0]  new_len;

  assign byte_stall = (q_count == 2'd2);
  assign accept     = byte_valid && !byte_stall;

  always_comb begin
    held_bytes_next      = held_bytes;
    expected_length_next = expected_length;
    lead_offset_next     = lead_offset;
    byte_position_next   = byte_position;
    n_units              = '0;
    rescan               = 1'b0;
    new_len              = utf8seg_pkg::lead_length(byte_data.data_byte);
    for (int i = 0; i < utf8seg_pkg::MAX_UNITS; i++) begin
      e_off[i] = '0;
      e_len[i] = '0;
    end

    if (!byte_data.no_byte) begin
      rescan = 1'b1;
      if (held_bytes != 2'd0) begin
        if ((byte_data.data_byte & utf8seg_pkg::CONT_MASK) == utf8seg_pkg::CONT_CODE) begin
          rescan = 1'b0;
          if ({1'b0, held_bytes} + 3'd1 >= expected_length) begin
            e_off[n_units[1:0]] = lead_offset;
            e_len[n_units[1:0]] = expected_length;
            n_units = n_units + 3'd1;
            held_bytes_next      = '0;
            expected_length_next = '0;
          end else begin
            held_bytes_next = held_bytes + 2'd1;
          end
        end else begin
          // broken unit: lead and held continuations go out one byte each
          for (int k = 0; k < 3; k++) begin
            if (3'(k) < {1'b0, held_bytes}) begin
              e_off[n_units[1:0]] = utf8seg_pkg::sat_add(lead_offset, 3'(k));
              e_len[n_units[1:0]] = 3'd1;
              n_units = n_units + 3'd1;
            end
          end
          held_bytes_next      = '0;
          expected_length_next = '0;
        end
      end
      if (rescan) begin
        if (new_len == 3'd1) begin
          e_off[n_units[1:0]] = byte_position;
          e_len[n_units[1:0]] = 3'd1;
          n_units = n_units + 3'd1;
        end else begin
          lead_offset_next     = byte_position;
          held_bytes_next      = 2'd1;
          expected_length_next = new_len;
        end
      end
      byte_position_next = utf8seg_pkg::sat_add(byte_position, 3'd1);
    end

    if (byte_data.end_of_string) begin
      // unit cut off at string end
      for (int k = 0; k < 3; k++) begin
        if (3'(k) < {1'b0, held_bytes_next}) begin
          e_off[n_units[1:0]] = utf8seg_pkg::sat_add(lead_offset_next, 3'(k));
          e_len[n_units[1:0]] = 3'd1;
          n_units = n_units + 3'd1;
        end
      end
      if (n_units == 3'd0 && byte_data.no_byte && unit_counter == 16'd0) begin
        e_off[0] = '0;
        e_len[0] = '0;
        n_units  = 3'd1;
      end
    end

    unit_counter_next = utf8seg_pkg::sat_add(unit_counter, n_units);
    if (byte_data.end_of_string) begin
      held_bytes_next      = '0;
      expected_length_next = '0;
      lead_offset_next     = '0;
      byte_position_next   = '0;
      unit_counter_next    = '0;
    end

    bundle.count = n_units;
    for (int i = 0; i < utf8seg_pkg::MAX_UNITS; i++) begin
      bundle.units[i].unit_offset = e_off[i];
      bundle.units[i].unit_length = e_len[i];
      bundle.units[i].unit_index  = utf8seg_pkg::sat_add(unit_counter, 3'(i));
      bundle.units[i].last_unit   = byte_data.end_of_string && (3'(i) + 3'd1 == n_units);
    end
  end

  assign unit_valid = (q_count != 2'd0);
  assign unit_data  = q[q_rd].units[rp];
  assign unit_take  = unit_valid && !unit_stall;
  assign pop        = unit_take && ({1'b0, rp} + 3'd1 == q[q_rd].count);
  assign push       = accept && (n_units != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_bytes      <= '0;
      expected_length <= '0;
      lead_offset     <= '0;
      byte_position   <= '0;
      unit_counter    <= '0;
      q_count         <= '0;
      q_rd            <= 1'b0;
      q_wr            <= 1'b0;
      rp              <= '0;
    end else begin
      if (accept) begin
        held_bytes      <= held_bytes_next;
        expected_length <= expected_length_next;
        lead_offset     <= lead_offset_next;
        byte_position   <= byte_position_next;
        unit_counter    <= unit_counter_next;
      end
      if (push) q_wr <= ~q_wr;
      if (pop) begin
        q_rd <= ~q_rd;
        rp   <= '0;
      end else if (unit_take) begin
        rp <= rp + 2'd1;
      end
      q_count <= q_count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[q_wr] <= bundle;
  end

  // ---------------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk) disable iff (rst) q_count <= 2'd2)
    else $error("bundle queue overfilled");

  a_head_nonempty: assert property (@(posedge clk) disable iff (rst)
    unit_valid |-> ({1'b0, rp} < q[q_rd].count))
    else $error("read pointer beyond head bundle");

  a_open_unit: assert property (@(posedge clk) disable iff (rst)
    (held_bytes != 2'd0) |-> (expected_length > {1'b0, held_bytes}))
    else $error("open unit already complete");

  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && byte_data.end_of_string) |=>
      (held_bytes == 2'd0 && byte_position == 16'd0 && unit_counter == 16'd0))
    else $error("string end left decoder state behind");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (q_count == 2'd2) |-> !push)
    else $error("bundle written into a full queue");

endmodule
